// ===== src/am824_pkg.sv =====
`default_nettype none
package am824_pkg;

   localparam int unsigned DATA_W   = 8;
   localparam int unsigned PERIOD_W = 20;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SYT_SPAN     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_PERIOD = 1'b1;

   localparam logic [DATA_W-1:0]   SYT_RESET    = 8'd8;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd20833;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPD,
      ST_ANCH,
      ST_PTS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [32:0] delta;
   } pts_req_type;

endpackage
`default_nettype wire

// ===== src/am824_div.sv =====
`default_nettype none
module am824_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire am824_pkg::div_req_type req,
   output am824_pkg::div_rsp_type      rsp
);

   localparam int unsigned W  = am824_pkg::DATA_W;
   localparam int unsigned CW = $clog2(W);

   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;

   // one restoring step per cycle: shift in a dividend bit, subtract if it fits
   assign trial = {rem_ff[W-1:0], dvd_ff[W-1]};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
         end else begin
            rem_in = trial;
         end
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff[W-1:0];

endmodule
`default_nettype wire

// ===== src/am824_pts.sv =====
`default_nettype none
module am824_pts (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire am824_pkg::pts_req_type            req,
   input  wire logic [am824_pkg::PERIOD_W-1:0]    period,
   input  wire logic [63:0]                       anchor_time,
   output logic                                   valid,
   output logic [63:0]                            base
);

   localparam int unsigned PW = am824_pkg::PERIOD_W;
   localparam int unsigned MW = 33 + PW + 1;

   logic signed [MW-1:0] prod_ff, prod_in;
   logic [63:0]          base_ff, base_in;
   logic                 stg_ff, valid_ff, valid_in;

   assign prod_in = MW'($signed(req.delta) * $signed({1'b0, period}));
   assign base_in = anchor_time + 64'(prod_ff);

   always_comb begin
      valid_in = valid_ff;
      if (req.start) begin
         valid_in = 1'b0;
      end else if (stg_ff) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         stg_ff   <= req.start;
         valid_ff <= valid_in;
      end
      if (req.start) begin
         prod_ff <= prod_in;
      end
      if (stg_ff) begin
         base_ff <= base_in;
      end
   end

   assign valid = valid_ff;
   assign base  = base_ff;

endmodule
`default_nettype wire

// ===== src/am824_stream_timing_tracker.sv =====
`default_nettype none
// channel  | ports             | tdata (low bit up)                           | tuser
// ---------+-------------------+----------------------------------------------+------------
// req      | req_t*            | seq_num, block_count, avtp_ts, now_ns        | ts_valid
// rsp      | rsp_t*            | base_pts_ns, gap_total, anchor_updates,      | anchor_ok,
//          |                   | packets_seen                                 | gap_seen
// csr      | csr_we/index/wdata| 0 syt span (blocks), 1 block period (ns)     | -
//
// An item passes the divider, then the update, anchor, PTS and done states, before its
// result register is loaded; no new item is taken until then. The 8-step compare/subtract
// divider computes dbc mod the syt span.
// req_tready is high only in idle; one item is in flight at a time.
// A pending result waits in the rsp register; the block idles only until it can load it.
// Synchronous active-high reset clears all tracking state and counters.
module am824_stream_timing_tracker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [111:0]  req_tdata,   // seq_num, block_count, avtp_ts, now_ns
   input  wire logic          req_tuser,   // ts_valid
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [159:0]       rsp_tdata,   // base_pts_ns, gap_total, anchor_updates,
                                           // packets_seen
   output logic [1:0]         rsp_tuser,   // anchor_ok, gap_seen
   input  wire logic          csr_we,
   input  wire logic [am824_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [am824_pkg::PERIOD_W-1:0]  csr_wdata
);

   localparam int unsigned W  = am824_pkg::DATA_W;
   localparam int unsigned PW = am824_pkg::PERIOD_W;

   am824_pkg::state_type state_ff, state_in;
   am824_pkg::div_req_type div_req;
   am824_pkg::div_rsp_type div_rsp;
   am824_pkg::pts_req_type pts_req;

   logic [W-1:0]  syt_ff;
   logic [PW-1:0] period_ff;

   logic [W-1:0]  seq_ff, dbc_ff;
   logic          tv_ff;
   logic [31:0]   ts_ff;
   logic [63:0]   now_ff;
   logic [W-1:0]  offs_ff;
   logic          upd_ff;

   logic [W-1:0]  prev_seq_ff, prev_dbc_ff;
   logic [31:0]   running_ff, anchor_blocks_ff;
   logic [63:0]   anchor_time_ff;
   logic          anchor_ff;
   logic [31:0]   pkt_cnt_ff, upd_cnt_ff, gap_cnt_ff;
   logic          gap_ff;

   logic          rsp_valid_ff;
   logic [159:0]  rsp_data_ff;
   logic [1:0]    rsp_user_ff;

   logic          accept, do_upd, do_anch, do_load, out_free;
   logic          pts_start;
   logic          pts_valid;
   logic [63:0]   pts_base;
   logic [31:0]   ahead;
   logic [63:0]   ahead_ext;
   logic          first_pkt, gap_now;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         am824_pkg::ST_IDLE: if (accept)       state_in = am824_pkg::ST_DIV;
         am824_pkg::ST_DIV:  if (div_rsp.done) state_in = am824_pkg::ST_UPD;
         am824_pkg::ST_UPD:  state_in = am824_pkg::ST_ANCH;
         am824_pkg::ST_ANCH: state_in = am824_pkg::ST_PTS;
         am824_pkg::ST_PTS:  state_in = am824_pkg::ST_DONE;
         am824_pkg::ST_DONE: if (pts_valid && out_free) state_in = am824_pkg::ST_IDLE;
         default:            state_in = am824_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      do_upd     = 1'b0;
      do_anch    = 1'b0;
      pts_start  = 1'b0;
      do_load    = 1'b0;
      unique case (state_ff)
         am824_pkg::ST_IDLE: req_tready = 1'b1;
         am824_pkg::ST_DIV:  ;
         am824_pkg::ST_UPD:  do_upd     = 1'b1;
         am824_pkg::ST_ANCH: do_anch    = 1'b1;
         am824_pkg::ST_PTS:  pts_start  = 1'b1;
         am824_pkg::ST_DONE: do_load    = pts_valid && out_free;
         default:            ;
      endcase
   end

   assign div_req.start    = accept;
   assign div_req.dividend = req_tdata[15:8];
   assign div_req.divisor  = syt_ff;

   am824_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign pts_req.start = pts_start;
   assign pts_req.delta = {1'b0, running_ff} - {1'b0, anchor_blocks_ff};

   am824_pts u_pts (
      .clock       (clock),
      .reset       (reset),
      .req         (pts_req),
      .period      (period_ff),
      .anchor_time (anchor_time_ff),
      .valid       (pts_valid),
      .base        (pts_base)
   );

   // nearest 64-bit time to now whose low word is the timestamp; tie goes later
   assign ahead     = ts_ff - now_ff[31:0];
   assign ahead_ext = (ahead > 32'h8000_0000) ? {32'hFFFF_FFFF, ahead} : {32'h0, ahead};
   assign first_pkt = (pkt_cnt_ff == '0);
   assign gap_now   = !first_pkt && (seq_ff != prev_seq_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= am824_pkg::ST_IDLE;
         syt_ff           <= am824_pkg::SYT_RESET;
         period_ff        <= am824_pkg::PERIOD_RESET;
         prev_seq_ff      <= '0;
         prev_dbc_ff      <= '0;
         running_ff       <= '0;
         anchor_blocks_ff <= '0;
         anchor_time_ff   <= '0;
         anchor_ff        <= 1'b0;
         pkt_cnt_ff       <= '0;
         upd_cnt_ff       <= '0;
         gap_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               am824_pkg::CSR_SYT_SPAN:     syt_ff    <= csr_wdata[W-1:0];
               am824_pkg::CSR_BLOCK_PERIOD: period_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (do_upd) begin
            prev_seq_ff <= seq_ff;
            prev_dbc_ff <= dbc_ff;
            if (first_pkt) begin
               running_ff <= {24'h0, dbc_ff};
            end else begin
               running_ff <= running_ff + {24'h0, 8'(dbc_ff - prev_dbc_ff)};
            end
            if (gap_now) begin
               gap_cnt_ff <= gap_cnt_ff + 1'b1;
            end
            if (upd_ff) begin
               anchor_time_ff <= now_ff + ahead_ext;
               upd_cnt_ff     <= upd_cnt_ff + 1'b1;
            end
            pkt_cnt_ff <= pkt_cnt_ff + 1'b1;
         end
         if (do_anch && upd_ff) begin
            anchor_blocks_ff <= running_ff + {24'h0, offs_ff};
            anchor_ff        <= 1'b1;
         end
         if (do_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         seq_ff <= req_tdata[7:0];
         dbc_ff <= req_tdata[15:8];
         ts_ff  <= req_tdata[47:16];
         now_ff <= req_tdata[111:48];
         tv_ff  <= req_tuser;
      end
      if (state_ff == am824_pkg::ST_DIV && div_rsp.done) begin
         offs_ff <= (div_rsp.rem == '0) ? '0 : syt_ff - div_rsp.rem;
         upd_ff  <= tv_ff && (syt_ff != '0);
      end
      if (do_upd) begin
         gap_ff <= gap_now;
      end
      if (do_load) begin
         rsp_data_ff <= {pkt_cnt_ff, upd_cnt_ff, gap_cnt_ff,
                         anchor_ff ? pts_base : 64'h0};
         rsp_user_ff <= {gap_ff, anchor_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ===== tb/sv/am824_stream_timing_tracker_tb.sv =====
`timescale 1ns / 1ps
module am824_stream_timing_tracker_tb;

   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_LEN     = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 50;

   typedef struct packed {
      logic [63:0] now_ns;
      logic [31:0] ts;
      logic        tv;
      logic [7:0]  dbc;
      logic [7:0]  seq;
   } pkt_hdr_type;

   typedef struct {
      logic [63:0] base_pts;
      logic        anchor_ok;
      logic        gap_seen;
      logic [31:0] gap_total;
      logic [31:0] anchor_updates;
      logic [31:0] packets_seen;
   } pts_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [111:0]         req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [159:0]         rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 csr_we = 1'b0;
   logic [am824_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [am824_pkg::PERIOD_W-1:0]  csr_wdata = '0;

   am824_stream_timing_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // tracker copy: configuration and state
   logic [7:0]  syt_cfg = am824_pkg::SYT_RESET;
   logic [19:0] period_cfg = am824_pkg::PERIOD_RESET;
   logic [7:0]  prev_seq_r = '0;
   logic [7:0]  prev_dbc_r = '0;
   logic [31:0] run_blocks = '0;
   logic [31:0] anchor_blk = '0;
   logic [63:0] anchor_t = '0;
   logic        has_anchor = 1'b0;
   logic [31:0] pkt_cnt = '0;
   logic [31:0] upd_cnt = '0;
   logic [31:0] gap_cnt = '0;

   pkt_hdr_type    hdr_pend_q[$];
   pts_result_type pts_expect_q[$];
   pts_result_type want;

   int          sender_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_asked = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          err_count = 0;
   int          idle_cycles = 0;
   logic        req_taken = 1'b0;

   logic [7:0]  gen_seq = '0;
   logic [7:0]  gen_dbc = '0;
   logic [63:0] gen_now = '0;

   function automatic pts_result_type track_packet(input pkt_hdr_type h);
      pts_result_type r;
      logic [31:0] ahead;
      logic [7:0]  offs;
      logic [63:0] delta;
      r.gap_seen = 1'b0;
      if (pkt_cnt != 0 && h.seq != prev_seq_r + 8'd1) begin
         r.gap_seen = 1'b1;
         gap_cnt = gap_cnt + 32'd1;
      end
      prev_seq_r = h.seq;
      // first packet loads the running count, later ones add the 8-bit dbc step
      if (pkt_cnt == 0)
         run_blocks = {24'd0, h.dbc};
      else
         run_blocks = run_blocks + {24'd0, h.dbc - prev_dbc_r};
      prev_dbc_r = h.dbc;
      if (h.tv && syt_cfg != 0) begin
         offs = (syt_cfg - h.dbc % syt_cfg) % syt_cfg;
         ahead = h.ts - h.now_ns[31:0];
         // exact half-range tie resolves to the later time
         if (ahead <= 32'h8000_0000)
            anchor_t = h.now_ns + {32'd0, ahead};
         else
            anchor_t = h.now_ns - (64'h1_0000_0000 - {32'd0, ahead});
         anchor_blk = run_blocks + {24'd0, offs};
         has_anchor = 1'b1;
         upd_cnt = upd_cnt + 32'd1;
      end
      pkt_cnt = pkt_cnt + 32'd1;
      r.base_pts = '0;
      if (has_anchor) begin
         // 33-bit signed block difference, carried in 64 bits
         delta = {32'd0, run_blocks} - {32'd0, anchor_blk};
         r.base_pts = anchor_t + delta * {44'd0, period_cfg};
      end
      r.anchor_ok = has_anchor;
      r.gap_total = gap_cnt;
      r.anchor_updates = upd_cnt;
      r.packets_seen = pkt_cnt;
      return r;
   endfunction

   task automatic check_field(input string what, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
      if (exp_v !== got_v) begin
         if (err_count < MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
         err_count++;
      end
   endtask

   // monitor: predicts on accepted items, checks accepted results
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            pts_expect_q.push_back(track_packet(
               pkt_hdr_type'({req_tdata[111:16], req_tuser, req_tdata[15:0]})));
         if (rsp_tvalid && rsp_tready) begin
            if (pts_expect_q.size() == 0) begin
               if (err_count < MAX_REPORTS)
                  $display("%0t: unexpected result: expected none, got %h / %b",
                           $time, rsp_tdata, rsp_tuser);
               err_count++;
            end else begin
               want = pts_expect_q.pop_front();
               check_field("base_pts_ns", want.base_pts, rsp_tdata[63:0]);
               check_field("gap_total", 64'(want.gap_total), 64'(rsp_tdata[95:64]));
               check_field("anchor_updates", 64'(want.anchor_updates),
                           64'(rsp_tdata[127:96]));
               check_field("packets_seen", 64'(want.packets_seen),
                           64'(rsp_tdata[159:128]));
               check_field("anchor_ok", 64'(want.anchor_ok), 64'(rsp_tuser[0]));
               check_field("gap_seen", 64'(want.gap_seen), 64'(rsp_tuser[1]));
            end
         end
      end
   end

   // driver for the request side
   always @(negedge clock) begin : req_drv
      pkt_hdr_type h;
      if (!req_tvalid || req_taken) begin
         if (hdr_pend_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            h = hdr_pend_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {h.now_ns, h.ts, h.dbc, h.seq};
            req_tuser  <= h.tv;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side backpressure, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left = HOLD_LEN;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= rsp_stall_pct;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [am824_pkg::CSR_IDX_W-1:0] idx,
                            input logic [19:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == am824_pkg::CSR_SYT_SPAN)
         syt_cfg = value[7:0];
      else if (idx == am824_pkg::CSR_BLOCK_PERIOD)
         period_cfg = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (hdr_pend_q.size() != 0 || req_tvalid || pts_expect_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic void push_hdr(input logic [7:0] seq, input logic [7:0] dbc,
                                    input logic tv, input logic [31:0] ts,
                                    input logic [63:0] now_ns);
      pkt_hdr_type h;
      h.seq = seq;
      h.dbc = dbc;
      h.tv = tv;
      h.ts = ts;
      h.now_ns = now_ns;
      hdr_pend_q.push_back(h);
   endfunction

   // mostly in-order streams with plausible timing, some random noise
   task automatic gen_headers(input int count);
      logic [7:0] step;
      logic [31:0] ts;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            step = (syt_cfg != 0) ? syt_cfg : 8'd8;
            if ($urandom_range(0, 3) == 0)
               step = 8'($urandom_range(0, 255));
            gen_seq = gen_seq + 8'd1;
            gen_dbc = gen_dbc + step;
            gen_now = gen_now + 64'($urandom_range(1, 5000000));
            ts = gen_now[31:0] + $urandom_range(0, 4000000);
            if ($urandom_range(0, 7) == 0)
               ts = $urandom;
            push_hdr(gen_seq, gen_dbc, 1'($urandom_range(0, 1)), ts, gen_now);
         end else begin
            gen_seq = 8'($urandom_range(0, 255));
            gen_dbc = 8'($urandom_range(0, 255));
            gen_now = {$urandom, $urandom};
            push_hdr(gen_seq, gen_dbc, 1'($urandom_range(0, 1)), $urandom, gen_now);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset configuration, no idling
      push_hdr(8'h10, 8'd0, 1'b0, 32'd0, 64'd0);
      push_hdr(8'h11, 8'd8, 1'b1, 32'd1000, 64'd500);
      push_hdr(8'h12, 8'd16, 1'b0, 32'd0, 64'd900);
      push_hdr(8'h20, 8'd3, 1'b1, 32'hFFFF_FFFF, 64'd0);
      push_hdr(8'h21, 8'd255, 1'b1, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_hdr(8'h22, 8'd5, 1'b1, 32'hA345_6789, 64'h0000_0001_2345_6789);
      push_hdr(8'h23, 8'd13, 1'b1, 32'h2345_6789, 64'h0000_0001_A345_6789);
      push_hdr(8'hFF, 8'd0, 1'b0, 32'd0, 64'h0000_0002_0000_0000);
      push_hdr(8'h00, 8'd8, 1'b0, 32'd0, 64'h0000_0002_0000_1000);
      push_hdr(8'h01, 8'd3, 1'b1, 32'h0000_2000, 64'h0000_0002_0000_1000);
      push_hdr(8'h02, 8'd3, 1'b0, 32'd0, 64'h0000_0002_0000_3000);
      push_hdr(8'h03, 8'd200, 1'b1, 32'h8000_0000, 64'h8000_0000_7FFF_FFFF);
      wait_drained();

      // anchoring disabled, period above nominal max; junk in upper wdata bits
      write_reg(am824_pkg::CSR_SYT_SPAN, {12'($urandom), 8'd0});
      write_reg(am824_pkg::CSR_BLOCK_PERIOD, 20'hFFFFF);
      push_hdr(8'h04, 8'd208, 1'b1, 32'h1234_5678, 64'h0000_0003_0000_0000);
      push_hdr(8'h05, 8'd210, 1'b0, 32'd0, 64'h0000_0003_0000_1000);
      push_hdr(8'h07, 8'd40, 1'b1, 32'd5, 64'd10);
      wait_drained();

      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      write_reg(am824_pkg::CSR_SYT_SPAN, 20'd1);
      write_reg(am824_pkg::CSR_BLOCK_PERIOD, 20'd1000000);
      gen_headers(100);
      wait_drained();

      sender_idle_pct = 85;
      write_reg(am824_pkg::CSR_SYT_SPAN, 20'd255);
      write_reg(am824_pkg::CSR_BLOCK_PERIOD, 20'd0);
      gen_headers(100);
      wait_drained();

      sender_idle_pct = 0;
      rsp_stall_pct = 85;
      write_reg(am824_pkg::CSR_SYT_SPAN, 20'($urandom_range(2, 254)));
      write_reg(am824_pkg::CSR_BLOCK_PERIOD, 20'($urandom_range(1, 999999)));
      gen_headers(50);
      hold_asked = hold_asked + 1;
      gen_headers(50);
      // let everything drain before sending more, no config change
      wait_drained();
      gen_headers(20);
      wait_drained();

      sender_idle_pct = 18;
      rsp_stall_pct = 18;
      write_reg(am824_pkg::CSR_SYT_SPAN, 20'd8);
      write_reg(am824_pkg::CSR_BLOCK_PERIOD, 20'd20833);
      gen_headers(100);
      wait_drained();

      if (err_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
